[hw/rtl/bra_pkg.sv]
// shared types and codes for the bitmap run allocator
package bra_pkg;

   // request operation codes, the fourth code is a no-op
   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_QUERY = 2'd2
   } op_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_CLEAR = 3'd0,
      ST_IDLE  = 3'd1,
      ST_SETUP = 3'd2,
      ST_READ  = 3'd3,
      ST_SCAN  = 3'd4,
      ST_RESP  = 3'd5
   } state_type;

   // field widths of the request and response
   localparam int OpBits   = 2;
   localparam int LenBits  = 6;
   localparam int SlotBits = 8;

endpackage

[hw/rtl/bra_fit.sv]
// parallel first-fit search of a free run inside one bitmap word
module bra_fit #(
   parameter int WORD_BITS = 32
) (
   input  logic [WORD_BITS-1:0]                  word,
   input  logic [bra_pkg::LenBits-1:0]           run_length,
   output logic [WORD_BITS-1:0]                  run_mask,
   output logic                                  found,
   output logic [$clog2(WORD_BITS)-1:0]          pos
);

   localparam int BW = $clog2(WORD_BITS);

   logic [2*WORD_BITS-1:0] ext;
   logic [WORD_BITS-1:0]   fit;

   // ones in the low run_length bits, clamped to the word
   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         run_mask[i] = (32'(run_length) > i);
      end
   end

   // positions past the word end see used bits, so the run cannot hang over
   assign ext = {{WORD_BITS{1'b1}}, word};

   always_comb begin
      for (int b = 0; b < WORD_BITS; b++) begin
         fit[b] = ((WORD_BITS'(ext >> b) & run_mask) == '0);
      end
   end

   // lowest fitting position
   always_comb begin
      pos = '0;
      for (int b = WORD_BITS - 1; b >= 0; b--) begin
         if (fit[b]) begin
            pos = BW'(b);
         end
      end
   end

   assign found = |fit;

endmodule

[hw/rtl/bitmap_run_allocator.sv]
// bitmap run allocator top level: sequencer, bitmap memory and response register
//
// Contiguous next-fit allocator over a used-bit map of SLOT_COUNT slots kept as
// SLOT_COUNT / WORD_BITS words in a single-port-read memory. After reset the block
// clears the map one word at a time and takes no request meanwhile.
// One request is worked on at a time: each passes the setup, read, scan and
// response states before the next accept; allocate stays in scan for each word
// scanned (1 up to SLOT_COUNT / WORD_BITS, 1 to 6 at the default size), starting
// at the word of the last fit. The scan reads one word per cycle through the memory
// read port into one shared fit unit. A finished response waits in an output
// register, so the next request can be accepted before it is taken.
module bitmap_run_allocator #(
   parameter int SLOT_COUNT = 192,
   parameter int WORD_BITS  = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [bra_pkg::OpBits-1:0]    req_opcode,
   input  logic [bra_pkg::LenBits-1:0]   req_run_length,
   input  logic [bra_pkg::SlotBits-1:0]  req_slot_index,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_status,
   output logic [bra_pkg::SlotBits-1:0]  rsp_first_slot,
   output logic                          rsp_slot_used
);

   localparam int WORD_COUNT = SLOT_COUNT / WORD_BITS;
   localparam int WIDX       = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
   localparam int BW         = $clog2(WORD_BITS);
   localparam int SW         = $clog2(SLOT_COUNT) + 1;
   localparam int SB         = bra_pkg::SlotBits;
   localparam int RSH        = 16;
   localparam int RECIP      = (2 ** RSH + WORD_BITS - 1) / WORD_BITS;
   localparam int PW         = SB + RSH + 1;

   bra_pkg::state_type state_ff, state_in;

   logic [bra_pkg::OpBits-1:0]  op_ff, op_in;
   logic [bra_pkg::LenBits-1:0] len_ff, len_in;
   logic [SB-1:0]               slot_ff, slot_in;
   logic [SB-1:0]               quot_ff, quot_in;
   logic [BW-1:0]               bit_ff, bit_in;
   logic                        addr_ok_ff, addr_ok_in;
   logic [WIDX-1:0]             word_ff, word_in;
   logic [WIDX-1:0]             cnt_ff, cnt_in;
   logic [WIDX-1:0]             start_ff, start_in;

   logic                        res_status_ff, res_status_in;
   logic [SB-1:0]               res_first_ff, res_first_in;
   logic                        res_used_ff, res_used_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic                        rsp_status_ff, rsp_status_in;
   logic [SB-1:0]               rsp_first_ff, rsp_first_in;
   logic                        rsp_used_ff, rsp_used_in;

   logic [WORD_BITS-1:0] mem [WORD_COUNT];
   logic [WORD_BITS-1:0] rd_data_ff;
   logic [WIDX-1:0]      rd_addr;
   logic                 wr_en;
   logic [WIDX-1:0]      wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   logic [WORD_BITS-1:0] run_mask;
   logic                 fit_found;
   logic [BW-1:0]        fit_pos;
   logic [WORD_BITS-1:0] free_mask;
   logic [WORD_BITS-1:0] alloc_mask;
   logic [WIDX-1:0]      next_word;
   logic [PW-1:0]        quot_prod;
   logic [SB-1:0]        quot;
   logic [SB-1:0]        rem;
   logic [SW-1:0]        first_full;
   logic                 len_ok;
   logic                 slot_ok;

   // shared fit unit over the word just read
   bra_fit #(
      .WORD_BITS (WORD_BITS)
   ) u_fit (
      .word       (rd_data_ff),
      .run_length (len_ff),
      .run_mask   (run_mask),
      .found      (fit_found),
      .pos        (fit_pos)
   );

   // word index by reciprocal multiply, exact for 8-bit slot indices
   assign quot_prod = PW'(slot_ff) * PW'(RECIP);
   assign quot      = SB'(quot_prod >> RSH);
   assign slot_ok   = (32'(slot_ff) < 32'(SLOT_COUNT)) && (32'(quot) < 32'(WORD_COUNT));

   // bit position inside the word
   assign rem = slot_ff - SB'(16'(quot_ff) * 16'(WORD_BITS));

   assign len_ok     = (len_ff != '0) && (32'(len_ff) <= 32'(WORD_BITS));
   assign next_word  = (32'(word_ff) == WORD_COUNT - 1) ? '0 : WIDX'(word_ff + 1'b1);
   assign free_mask  = run_mask << bit_ff;
   assign alloc_mask = run_mask << fit_pos;
   assign first_full = SW'(SW'(word_ff) * SW'(WORD_BITS)) + SW'(fit_pos);

   // bitmap memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // sequencer next state and outputs
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      len_in        = len_ff;
      slot_in       = slot_ff;
      quot_in       = quot_ff;
      bit_in        = bit_ff;
      addr_ok_in    = addr_ok_ff;
      word_in       = word_ff;
      cnt_in        = cnt_ff;
      start_in      = start_ff;
      res_status_in = res_status_ff;
      res_first_in  = res_first_ff;
      res_used_in   = res_used_ff;
      rsp_valid_in  = rsp_valid_ff & ~rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_first_in  = rsp_first_ff;
      rsp_used_in   = rsp_used_ff;
      req_ready     = 1'b0;
      rd_addr       = word_ff;
      wr_en         = 1'b0;
      wr_addr       = word_ff;
      wr_data       = '0;

      unique case (state_ff)
         // sweep zeros through the map after reset
         bra_pkg::ST_CLEAR: begin
            wr_en = 1'b1;
            if (32'(word_ff) == WORD_COUNT - 1) begin
               word_in  = '0;
               state_in = bra_pkg::ST_IDLE;
            end else begin
               word_in = WIDX'(word_ff + 1'b1);
            end
         end

         // take a request
         bra_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               op_in    = req_opcode;
               len_in   = req_run_length;
               slot_in  = req_slot_index;
               state_in = bra_pkg::ST_SETUP;
            end
         end

         // pick the first word to read
         bra_pkg::ST_SETUP: begin
            quot_in    = quot;
            addr_ok_in = slot_ok;
            cnt_in     = '0;
            if (op_ff == bra_pkg::OP_ALLOC) begin
               word_in = start_ff;
            end else begin
               word_in = WIDX'(quot);
            end
            state_in = bra_pkg::ST_READ;
         end

         // first word read in flight
         bra_pkg::ST_READ: begin
            rd_addr  = word_ff;
            bit_in   = BW'(rem);
            state_in = bra_pkg::ST_SCAN;
         end

         // evaluate the word read, prefetch the next one
         bra_pkg::ST_SCAN: begin
            rd_addr       = next_word;
            res_status_in = 1'b0;
            res_first_in  = '0;
            res_used_in   = 1'b0;
            state_in      = bra_pkg::ST_RESP;
            unique case (op_ff)
               bra_pkg::OP_ALLOC: begin
                  if (!len_ok) begin
                     res_status_in = 1'b1;
                  end else if (fit_found) begin
                     wr_en        = 1'b1;
                     wr_data      = rd_data_ff | alloc_mask;
                     start_in     = word_ff;
                     res_first_in = SB'(first_full);
                  end else if (32'(cnt_ff) == WORD_COUNT - 1) begin
                     res_status_in = 1'b1;
                  end else begin
                     word_in  = next_word;
                     cnt_in   = WIDX'(cnt_ff + 1'b1);
                     state_in = bra_pkg::ST_SCAN;
                  end
               end
               bra_pkg::OP_FREE: begin
                  if (addr_ok_ff && (len_ff != '0)) begin
                     wr_en   = 1'b1;
                     wr_data = rd_data_ff & ~free_mask;
                  end
               end
               bra_pkg::OP_QUERY: begin
                  res_used_in = addr_ok_ff & rd_data_ff[bit_ff];
               end
               default: begin
               end
            endcase
         end

         // hand the result to the output register once it is free
         bra_pkg::ST_RESP: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_first_in  = res_first_ff;
               rsp_used_in   = res_used_ff;
               state_in      = bra_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = bra_pkg::ST_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bra_pkg::ST_CLEAR;
         word_ff      <= '0;
         cnt_ff       <= '0;
         start_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         cnt_ff       <= cnt_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      len_ff        <= len_in;
      slot_ff       <= slot_in;
      quot_ff       <= quot_in;
      bit_ff        <= bit_in;
      addr_ok_ff    <= addr_ok_in;
      res_status_ff <= res_status_in;
      res_first_ff  <= res_first_in;
      res_used_ff   <= res_used_in;
      rsp_status_ff <= rsp_status_in;
      rsp_first_ff  <= rsp_first_in;
      rsp_used_ff   <= rsp_used_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_first_slot = rsp_first_ff;
   assign rsp_slot_used  = rsp_used_ff;

   // a new response only comes out of the response state
   a_rsp_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == bra_pkg::ST_RESP))
      else $error("response raised outside the response state");

   // an out of space answer carries no slot and no used bit
   a_oos_clean: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_status_ff) |-> (rsp_first_ff == '0) && !rsp_used_ff)
      else $error("out of space response with nonzero fields");

   // the scan never visits more words than the map has
   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == bra_pkg::ST_SCAN) |-> (32'(cnt_ff) <= WORD_COUNT - 1))
      else $error("scan counter past the last word");

   // the map is written only by the clear sweep or the evaluate step
   a_write_states: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == bra_pkg::ST_CLEAR) || (state_ff == bra_pkg::ST_SCAN))
      else $error("bitmap written outside clear or scan");

   // a waiting response is never overwritten before it is taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_first_ff) && $stable(rsp_status_ff))
      else $error("pending response changed");

endmodule

[tb/tb_bitmap_run_allocator.sv]
// self-checking testbench for the bitmap run allocator with a next-fit prediction of the map
module tb_bitmap_run_allocator;

   localparam int SLOT_COUNT   = 192;
   localparam int WORD_BITS    = 32;
   localparam int WORD_COUNT   = SLOT_COUNT / WORD_BITS;
   localparam int GAP_MAX      = 19;
   localparam int DRAIN_CYCLES = 24;
   localparam logic [bra_pkg::OpBits-1:0] OP_NOP = 2'd3;

   typedef struct {
      logic                         status;
      logic [bra_pkg::SlotBits-1:0] first_slot;
      logic                         slot_used;
   } answer_type;

   typedef struct {
      logic [bra_pkg::SlotBits-1:0] slot;
      logic [bra_pkg::LenBits-1:0]  len;
   } run_type;

   logic                         clock = 1'b0;
   logic                         reset = 1'b1;
   logic                         req_valid = 1'b0;
   logic [bra_pkg::OpBits-1:0]   req_opcode = '0;
   logic [bra_pkg::LenBits-1:0]  req_run_length = '0;
   logic [bra_pkg::SlotBits-1:0] req_slot_index = '0;
   logic                         rsp_ready = 1'b0;
   logic                         req_ready;
   logic                         rsp_valid;
   logic                         rsp_status;
   logic [bra_pkg::SlotBits-1:0] rsp_first_slot;
   logic                         rsp_slot_used;

   // predicted allocator state
   logic [WORD_BITS-1:0] slot_map [WORD_COUNT];
   int unsigned          scan_word;

   answer_type  answers_due [$];
   run_type     live_runs [$];
   int unsigned error_count = 0;
   int unsigned work_items = 0;
   bit          req_gaps_on = 1'b1;
   bit          rsp_gaps_on = 1'b1;

   bitmap_run_allocator #(
      .SLOT_COUNT(SLOT_COUNT),
      .WORD_BITS (WORD_BITS)
   ) uut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_opcode    (req_opcode),
      .req_run_length(req_run_length),
      .req_slot_index(req_slot_index),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_first_slot(rsp_first_slot),
      .rsp_slot_used (rsp_slot_used)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // next-fit step over the predicted map, returns the answer for one request
   function automatic answer_type first_fit_step(logic [bra_pkg::OpBits-1:0] op,
                                                 logic [bra_pkg::LenBits-1:0] len,
                                                 logic [bra_pkg::SlotBits-1:0] slot);
      answer_type  a;
      int unsigned i, w, b, n;
      logic [63:0] run;
      bit          found;
      a = '{status: 1'b0, first_slot: '0, slot_used: 1'b0};
      found = 1'b0;
      case (op)
         bra_pkg::OP_ALLOC: begin
            if (len >= 1 && len <= WORD_BITS) begin
               run = (64'd1 << len) - 64'd1;
               for (i = 0; i < WORD_COUNT && !found; i++) begin
                  w = (scan_word + i) % WORD_COUNT;
                  for (b = 0; b + len <= WORD_BITS && !found; b++) begin
                     if ((slot_map[w] & WORD_BITS'(run << b)) == '0) begin
                        slot_map[w] = slot_map[w] | WORD_BITS'(run << b);
                        scan_word = w;
                        a.first_slot = bra_pkg::SlotBits'(w * WORD_BITS + b);
                        found = 1'b1;
                     end
                  end
               end
            end
            if (!found) begin
               a.status = 1'b1;
               a.first_slot = '0;
            end
         end
         bra_pkg::OP_FREE: begin
            // bits past the word end drop off, long runs clamp to a word
            if (slot < SLOT_COUNT && len != 0) begin
               w = slot / WORD_BITS;
               b = slot % WORD_BITS;
               n = (len > WORD_BITS) ? WORD_BITS : len;
               run = ((64'd1 << n) - 64'd1) << b;
               slot_map[w] = slot_map[w] & ~run[WORD_BITS-1:0];
            end
         end
         bra_pkg::OP_QUERY: begin
            if (slot < SLOT_COUNT)
               a.slot_used = slot_map[slot / WORD_BITS][slot % WORD_BITS];
         end
         default: ;
      endcase
      return a;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      error_count++;
   endtask

   // present one request after a random gap and predict its answer on accept
   task automatic send_request(input logic [bra_pkg::OpBits-1:0] op,
                               input logic [bra_pkg::LenBits-1:0] len,
                               input logic [bra_pkg::SlotBits-1:0] slot);
      int unsigned gap;
      answer_type  a;
      gap = req_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_opcode     <= op;
      req_run_length <= len;
      req_slot_index <= slot;
      do @(posedge clock); while (!req_ready);
      a = first_fit_step(op, len, slot);
      answers_due.push_back(a);
      if (op == bra_pkg::OP_ALLOC && a.status == 1'b0)
         live_runs.push_back('{slot: a.first_slot, len: len});
      if (op != OP_NOP)
         work_items++;
   endtask

   // hold off new requests until every answer has come back
   task automatic pause_until_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (answers_due.size() != 0);
   endtask

   task automatic test_after_reset();
      send_request(bra_pkg::OP_QUERY, 6'd1, 8'd0);
      send_request(bra_pkg::OP_QUERY, 6'd1, 8'd191);
      send_request(bra_pkg::OP_QUERY, 6'd1, 8'd192);
      send_request(bra_pkg::OP_QUERY, 6'd63, 8'd255);
      send_request(OP_NOP, 6'd63, 8'd255);
      send_request(OP_NOP, 6'd0, 8'd0);
   endtask

   task automatic test_alloc_lengths();
      // zero and over-long lengths never fit
      send_request(bra_pkg::OP_ALLOC, 6'd0, 8'd0);
      send_request(bra_pkg::OP_ALLOC, 6'd33, 8'd0);
      send_request(bra_pkg::OP_ALLOC, 6'd63, 8'd255);
      // whole word, then spill into the following words
      send_request(bra_pkg::OP_ALLOC, 6'd32, 8'd255);
      send_request(bra_pkg::OP_ALLOC, 6'd1, 8'd0);
      send_request(bra_pkg::OP_ALLOC, 6'd31, 8'd0);
      send_request(bra_pkg::OP_ALLOC, 6'd1, 8'd0);
   endtask

   task automatic test_free_edges();
      // run crossing the word end, clamped length, zero length, slot off the map
      send_request(bra_pkg::OP_FREE, 6'd10, 8'd60);
      send_request(bra_pkg::OP_QUERY, 6'd0, 8'd60);
      send_request(bra_pkg::OP_QUERY, 6'd0, 8'd59);
      send_request(bra_pkg::OP_FREE, 6'd63, 8'd32);
      send_request(bra_pkg::OP_QUERY, 6'd0, 8'd40);
      send_request(bra_pkg::OP_FREE, 6'd0, 8'd0);
      send_request(bra_pkg::OP_QUERY, 6'd0, 8'd0);
      send_request(bra_pkg::OP_FREE, 6'd5, 8'd200);
      send_request(bra_pkg::OP_FREE, 6'd63, 8'd255);
   endtask

   task automatic test_fill_and_wrap();
      int unsigned k;
      // fill every word, run out of space, then wrap back to a freed word
      for (k = 0; k < 5; k++)
         send_request(bra_pkg::OP_ALLOC, 6'd32, 8'd0);
      send_request(bra_pkg::OP_ALLOC, 6'd31, 8'd0);
      send_request(bra_pkg::OP_ALLOC, 6'd1, 8'd0);
      send_request(bra_pkg::OP_FREE, 6'd32, 8'd96);
      send_request(bra_pkg::OP_ALLOC, 6'd32, 8'd0);
      send_request(bra_pkg::OP_QUERY, 6'd0, 8'd127);
   endtask

   task automatic test_random_traffic(input int unsigned target);
      int unsigned sel, idx, mode, phase_left;
      run_type     r;
      logic [bra_pkg::LenBits-1:0] len;
      phase_left = 0;
      while (work_items < target) begin
         // new idling pattern every phase, about one phase in four begins with a full drain
         if (phase_left == 0) begin
            mode = $urandom_range(0, 3);
            req_gaps_on = mode[0];
            rsp_gaps_on = mode[1];
            phase_left = $urandom_range(60, 160);
            if ($urandom_range(0, 3) == 0)
               pause_until_drained();
         end
         phase_left--;
         sel = $urandom_range(0, 99);
         if (live_runs.size() > 24 && sel >= 10 && sel < 50)
            sel = sel + 40;
         if (sel < 10) begin
            send_request(bra_pkg::OpBits'($urandom_range(0, 3)),
                         bra_pkg::LenBits'($urandom_range(0, 63)),
                         bra_pkg::SlotBits'($urandom_range(0, 255)));
         end else if (sel < 50) begin
            len = ($urandom_range(0, 3) == 0) ? bra_pkg::LenBits'($urandom_range(1, 32))
                                              : bra_pkg::LenBits'($urandom_range(1, 8));
            send_request(bra_pkg::OP_ALLOC, len, bra_pkg::SlotBits'($urandom_range(0, 255)));
         end else if (sel < 85) begin
            if (live_runs.size() != 0) begin
               idx = $urandom_range(0, live_runs.size() - 1);
               r = live_runs[idx];
               live_runs.delete(idx);
               len = ($urandom_range(0, 7) == 0) ? bra_pkg::LenBits'($urandom_range(1, 63))
                                                 : r.len;
               send_request(bra_pkg::OP_FREE, len, r.slot);
            end else begin
               send_request(bra_pkg::OP_FREE, bra_pkg::LenBits'($urandom_range(1, 32)),
                            bra_pkg::SlotBits'($urandom_range(0, SLOT_COUNT - 1)));
            end
         end else begin
            if (live_runs.size() != 0 && sel < 93) begin
               r = live_runs[$urandom_range(0, live_runs.size() - 1)];
               send_request(bra_pkg::OP_QUERY, bra_pkg::LenBits'($urandom_range(0, 63)),
                            bra_pkg::SlotBits'(r.slot + $urandom_range(0, r.len)));
            end else begin
               send_request(bra_pkg::OP_QUERY, bra_pkg::LenBits'($urandom_range(0, 63)),
                            bra_pkg::SlotBits'($urandom_range(0, SLOT_COUNT - 1)));
            end
         end
      end
   endtask

   // response side: random stalls, compare each response with the oldest answer
   initial begin : rsp_side
      int unsigned stall;
      answer_type  want;
      while (reset) @(posedge clock);
      forever begin
         stall = rsp_gaps_on ? $urandom_range(0, GAP_MAX) : 0;
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if (answers_due.size() == 0) begin
            report_mismatch($sformatf("response with no request pending, first_slot %0d",
                                      rsp_first_slot));
         end else begin
            want = answers_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("status got %b expected %b",
                                         rsp_status, want.status));
            if (rsp_first_slot !== want.first_slot)
               report_mismatch($sformatf("first_slot got %0d expected %0d",
                                         rsp_first_slot, want.first_slot));
            if (rsp_slot_used !== want.slot_used)
               report_mismatch($sformatf("slot_used got %b expected %b",
                                         rsp_slot_used, want.slot_used));
         end
      end
   end

   // request side: directed tests then random traffic
   initial begin : req_side
      for (int w = 0; w < WORD_COUNT; w++)
         slot_map[w] = '0;
      scan_word = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_after_reset();
      test_alloc_lengths();
      test_free_edges();
      test_fill_and_wrap();
      test_random_traffic(1350);
      pause_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   // overall run limit
   initial begin : run_limit
      #8000000;
      $display("timeout with %0d responses outstanding", answers_due.size());
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
